// ===== sv/idle_gap_frame_receiver_top_macros.svh =====
// Assertion macros for the idle-gap frame receiver checker
`ifndef IDLE_GAP_FRAME_RECEIVER_TOP_MACROS_SVH
`define IDLE_GAP_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IGFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define IGFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/igfr_pkg.sv =====
// Package: widths, constants and defaults of the idle-gap frame receiver
package igfr_pkg;
	localparam int BUFFER_DEPTH_DEF = 64;
	localparam int IN_TDATA_W       = 8;
	localparam int OUT_TDATA_W      = 24;
	localparam int APB_ADDR_W       = 3;
	localparam int APB_DATA_W       = 32;
	localparam int GAP_W            = 16;
	localparam int BYTE_W           = 8;
	localparam int INDEX_W          = 6;
	localparam int LENGTH_W         = 7;
	localparam logic [GAP_W-1:0] IDLE_RELOAD = 16'd60000;
	localparam logic [GAP_W-1:0] GAP_RESET   = 16'd5;
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;
endpackage

// ===== sv/igfr_ram.sv =====
// Generic simple dual-port RAM with registered read
module igfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/idle_gap_frame_receiver_top.sv =====
// Top level: idle-gap frame receiver
//
// Input stream: one word per received byte (tuser = 0, byte in tdata) or per
// timer tick (tuser = 1). Bytes go into a buffer of BUFFER_DEPTH entries and
// reload a gap countdown from gap_ticks; a byte that finds the buffer full is
// dropped. Each tick decrements the countdown through one shared decrement
// and zero-compare unit. When it reaches zero, the held bytes leave on the
// output stream as one frame, one word per byte, tlast on the final byte,
// and the countdown reloads with 60000.
// Byte and tick words are accepted back to back while no frame is being sent. A tick
// that ends a frame holds s_axis_tready low until its final byte is taken,
// including output stall time: each byte passes through a buffer read state and
// an output state, set by the single registered read port of the buffer.
// A stall on m_axis_tready holds the current output word and the sequencer.
// gap_ticks is written over APB at addresses 0 to 3; pready is always high.
// Reset clears the byte count, loads the countdown with 60000 and gap_ticks
// with 5; buffer contents are not cleared.
module idle_gap_frame_receiver_top #(
	parameter int BUFFER_DEPTH = igfr_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [igfr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] rx_byte
	input  logic                              s_axis_tuser,  // [0] operation
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] frame_byte, [13:8] byte_index, [20:14] frame_length, [23:21] zero
	output logic [igfr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                              m_axis_tlast,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [igfr_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [igfr_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [igfr_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_SEND = 2'd2;

	logic [1:0]                       state_q;
	logic [CNT_W-1:0]                 count_q;
	logic [IDX_W-1:0]                 idx_q;
	logic [igfr_pkg::GAP_W-1:0]       countdown_q;
	logic [igfr_pkg::GAP_W-1:0]       gap_q;
	logic [igfr_pkg::BYTE_W-1:0]      byte_q;

	logic                             in_acc;
	logic                             out_acc;
	logic                             cfg_wr;
	logic                             byte_ok;
	logic                             last_w;
	logic [igfr_pkg::GAP_W-1:0]       cd_dec;
	logic [igfr_pkg::GAP_W-1:0]       reload;
	logic                             ram_we;
	logic [IDX_W-1:0]                 ram_raddr;
	logic [igfr_pkg::BYTE_W-1:0]      ram_rdata;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == S_SEND);
	assign out_acc = m_axis_tvalid && m_axis_tready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ?
		{{(igfr_pkg::APB_DATA_W - igfr_pkg::GAP_W){1'b0}}, gap_q} : '0;

	// shared countdown unit
	assign cd_dec  = countdown_q - igfr_pkg::GAP_W'(1);
	assign reload  = (gap_q == '0) ? igfr_pkg::GAP_W'(1) : gap_q;
	assign byte_ok = (countdown_q != '0) && (count_q < DEPTH_CNT);

	assign last_w = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	assign ram_we    = in_acc && (s_axis_tuser == igfr_pkg::OP_BYTE) && byte_ok;
	assign ram_raddr = (state_q == S_SEND) ? (idx_q + IDX_W'(1)) : '0;

	igfr_ram #(
		.WIDTH (igfr_pkg::BYTE_W),
		.DEPTH (BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (s_axis_tdata[igfr_pkg::BYTE_W-1:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			countdown_q <= igfr_pkg::IDLE_RELOAD;
			gap_q       <= igfr_pkg::GAP_RESET;
		end else begin
			if (cfg_wr) begin
				gap_q <= pwdata[igfr_pkg::GAP_W-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser == igfr_pkg::OP_BYTE) begin
							if (byte_ok) begin
								count_q     <= count_q + CNT_W'(1);
								countdown_q <= reload;
							end
						end else if (countdown_q != '0) begin
							if (cd_dec == '0) begin
								countdown_q <= igfr_pkg::IDLE_RELOAD;
								if (count_q != '0) begin
									idx_q   <= '0;
									state_q <= S_LOAD;
								end
							end else begin
								countdown_q <= cd_dec;
							end
						end
					end
				end
				S_LOAD: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (out_acc) begin
						if (last_w) begin
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			byte_q <= ram_rdata;
		end
	end

	assign m_axis_tdata = {
		{(igfr_pkg::OUT_TDATA_W - igfr_pkg::BYTE_W - igfr_pkg::INDEX_W
			- igfr_pkg::LENGTH_W){1'b0}},
		igfr_pkg::LENGTH_W'(count_q),
		igfr_pkg::INDEX_W'(idx_q),
		byte_q
	};
	assign m_axis_tlast = last_w;
endmodule

// ===== sv/igfr_checker.sv =====
// Port-level checker for the idle-gap frame receiver, bound to the top level
`include "idle_gap_frame_receiver_top_macros.svh"

module igfr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [igfr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                              m_axis_tlast,
	input logic                              pready
);
	// input is never taken while a frame word is on offer
	`IGFR_ASSERT_SAME(a_no_overlap, clk, arst_n, m_axis_tvalid, !s_axis_tready, "input ready during frame output")

	// a stalled output word holds
	`IGFR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed under stall")

	// after a non-final word the next cycle is a buffer read, with no output word and input not ready
	`IGFR_ASSERT_NEXT(a_read_gap, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid && !s_axis_tready, "no buffer read cycle between frame words")

	// after the final word the input opens again
	`IGFR_ASSERT_NEXT(a_frame_end, clk, arst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready && !m_axis_tvalid, "input not ready after frame end")

	`IGFR_ASSERT_SAME(a_pready, clk, arst_n, 1'b1, pready, "pready low")
endmodule

bind idle_gap_frame_receiver_top igfr_checker u_igfr_checker (.*);

// ===== tb/tb_idle_gap_frame_receiver_top.sv =====
// Testbench for the idle-gap frame receiver: directed and random word streams checked against a frame predictor
module tb_idle_gap_frame_receiver_top;
	import igfr_pkg::*;

	localparam int DEPTH         = BUFFER_DEPTH_DEF;
	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 32;
	localparam int PHASE_WORDS   = 24;
	localparam int NUM_PHASES    = 4;
	localparam int HOLD_CYCLES   = 500;
	localparam int MAX_REPORTS   = 10;
	localparam logic [APB_ADDR_W-1:0] REG_GAP_TICKS = '0;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   data;
		logic [INDEX_W-1:0]  index;
		logic [LENGTH_W-1:0] length;
		logic                last;
	} frame_word_t;

	class frame_scoreboard;
		logic [GAP_W-1:0]  gap_ticks;
		logic [GAP_W-1:0]  countdown;
		int                held;
		logic [BYTE_W-1:0] frame_buf [DEPTH];
		frame_word_t       frame_words [$];
		int                errors;

		function new();
			gap_ticks = GAP_RESET;
			countdown = IDLE_RELOAD;
			held = 0;
			errors = 0;
		endfunction

		function void set_gap(logic [GAP_W-1:0] value);
			gap_ticks = value;
		endfunction

		function int pending();
			return frame_words.size();
		endfunction

		function void fail(string msg);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("mismatch: %s", msg);
			end
		endfunction

		function void note_word(logic op, logic [BYTE_W-1:0] data);
			frame_word_t w;
			if (op == OP_BYTE) begin
				// full buffer: byte dropped, countdown untouched
				if (countdown != 0 && held < DEPTH) begin
					countdown = (gap_ticks == 0) ? GAP_W'(1) : gap_ticks;
					frame_buf[held] = data;
					held++;
				end
				return;
			end
			if (countdown == 0) return;
			countdown--;
			if (countdown != 0) return;
			for (int k = 0; k < held; k++) begin
				w.data   = frame_buf[k];
				w.index  = INDEX_W'(k);
				w.length = LENGTH_W'(held);
				w.last   = (k == held - 1);
				frame_words.push_back(w);
			end
			held = 0;
			countdown = IDLE_RELOAD;
		endfunction

		function void check_word(frame_word_t got);
			frame_word_t want;
			if (frame_words.size() == 0) begin
				fail($sformatf("unexpected word byte %h index %0d length %0d last %b",
					got.data, got.index, got.length, got.last));
				return;
			end
			want = frame_words.pop_front();
			if (got.data !== want.data)
				fail($sformatf("frame_byte exp %h got %h", want.data, got.data));
			if (got.index !== want.index)
				fail($sformatf("byte_index exp %0d got %0d", want.index, got.index));
			if (got.length !== want.length)
				fail($sformatf("frame_length exp %0d got %0d", want.length, got.length));
			if (got.last !== want.last)
				fail($sformatf("tlast exp %b got %b (index %0d)", want.last, got.last, want.index));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	frame_scoreboard sb = new();
	idle_mode_t      mode = IDLE_NONE;
	int              hold_req = 0;
	int              words_sent = 0;

	idle_gap_frame_receiver_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_word(logic op, logic [BYTE_W-1:0] data);
		int pct;
		pct = (mode == IDLE_SENDER) ? 87 : (mode == IDLE_BOTH) ? 13 : 0;
		while ($urandom_range(0, 99) < pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(op, data);
		words_sent++;
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_word(OP_TICK, BYTE_W'($urandom));
	endtask

	// ticks until the held frame expires
	task automatic end_frame();
		while (sb.held > 0) send_word(OP_TICK, BYTE_W'($urandom));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gap(logic [GAP_W-1:0] value);
		logic [APB_DATA_W-1:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_GAP_TICKS;
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_gap(value);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== APB_DATA_W'(value))
			sb.fail($sformatf("gap_ticks readback exp %h got %h", value, readback));
	endtask

	// bytes with occasional short tick runs that stay inside the gap
	task automatic random_frame(int n);
		for (int k = 0; k < n; k++) begin
			send_word(OP_BYTE, BYTE_W'($urandom));
			if ($urandom_range(0, 5) == 0 && sb.countdown > 1)
				send_ticks($urandom_range(1, sb.countdown - 1));
		end
		end_frame();
	endtask

	task automatic run_phase(int words);
		int start;
		int pick;
		int n;
		start = words_sent;
		while (words_sent - start < words) begin
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
				random_frame(n);
			end else if (pick <= 8) begin
				send_word(1'($urandom_range(0, 1)), BYTE_W'($urandom));
			end else begin
				repeat ($urandom_range(1, 4)) send_word(OP_BYTE, BYTE_W'($urandom));
			end
		end
		end_frame();
		drain();
	endtask

	initial begin
		int pct;
		frame_word_t got;
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.data   = m_axis_tdata[BYTE_W-1:0];
				got.index  = m_axis_tdata[BYTE_W +: INDEX_W];
				got.length = m_axis_tdata[BYTE_W+INDEX_W +: LENGTH_W];
				got.last   = m_axis_tlast;
				sb.check_word(got);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			pct = (mode == IDLE_RECEIVER) ? 87 : (mode == IDLE_BOTH) ? 13 : 0;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else if (arst_n)
				quiet++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [GAP_W-1:0] gap;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gap value
		send_word(OP_BYTE, 8'h00);
		send_word(OP_BYTE, 8'hFF);
		send_ticks(GAP_RESET);
		// ticks that do not reach zero, then a byte reloads the gap
		send_ticks(3);
		send_word(OP_BYTE, 8'hA5);
		send_ticks(4);
		send_word(OP_BYTE, 8'h3C);
		end_frame();
		drain();

		// zero gap: byte reloads with one
		write_gap('0);
		send_word(OP_BYTE, 8'h5A);
		end_frame();
		drain();

		// full buffer: dropped byte must not reload the countdown
		write_gap(GAP_W'(3));
		for (int k = 0; k < DEPTH; k++) send_word(OP_BYTE, BYTE_W'(k * 37 + 1));
		send_ticks(2);
		send_word(OP_BYTE, 8'hEE);
		send_ticks(1);
		send_word(OP_BYTE, 8'h96);
		end_frame();
		drain();

		write_gap('1);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			mode = idle_mode_t'(p % 4);
			gap = (p == 3) ? GAP_W'(0) : (p == 0) ? GAP_W'(1) : GAP_W'($urandom_range(1, 8));
			write_gap(gap);
			if (p == 0) begin
				// long output hold-off while input keeps coming
				hold_req = HOLD_CYCLES;
				random_frame(48);
			end
			run_phase(PHASE_WORDS);
		end
		mode = IDLE_NONE;
		drain();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+sv
sv/igfr_pkg.sv
sv/igfr_ram.sv
sv/idle_gap_frame_receiver_top.sv
sv/igfr_checker.sv
tb/tb_idle_gap_frame_receiver_top.sv
